// ----- design/rv32_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32IM execute package
// Shared types, opcodes and command structures for the execute block.
// ----------------------------------------------------------------------------
package rv32_pkg;

   localparam logic [6:0] OpLui    = 7'b0110111;
   localparam logic [6:0] OpAuipc  = 7'b0010111;
   localparam logic [6:0] OpJal    = 7'b1101111;
   localparam logic [6:0] OpJalr   = 7'b1100111;
   localparam logic [6:0] OpBranch = 7'b1100011;
   localparam logic [6:0] OpLoad   = 7'b0000011;
   localparam logic [6:0] OpStore  = 7'b0100011;
   localparam logic [6:0] OpImm    = 7'b0010011;
   localparam logic [6:0] OpReg    = 7'b0110011;
   localparam logic [6:0] OpSystem = 7'b1110011;

   localparam logic [6:0] F7Base = 7'b0000000;
   localparam logic [6:0] F7Alt  = 7'b0100000;
   localparam logic [6:0] F7Mul  = 7'b0000001;

   localparam logic [31:0] WordEbreak = 32'h0010_0073;

   localparam logic [2:0] StDone    = 3'd0;
   localparam logic [2:0] StAwait   = 3'd1;
   localparam logic [2:0] StHalt    = 3'd2;
   localparam logic [2:0] StIllegal = 3'd3;
   localparam logic [2:0] StStray   = 3'd4;

   typedef struct packed {
      logic        mode;
      logic [31:0] instruction;
      logic [31:0] pc;
      logic [31:0] load_data;
   } req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        mem_valid;
      logic        mem_write;
      logic [2:0]  mem_bytes;
      logic [31:0] mem_address;
      logic [31:0] store_value;
      logic [2:0]  status;
      logic [31:0] halt_code;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_EXEC, S_MUL, S_DSTART, S_DIV, S_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic read;
      logic exec;
      logic mul_hi;
      logic div_start;
      logic div_step;
      logic div_finish;
   } cmd_type;

   typedef struct packed {
      logic is_data;
      logic is_mul;
      logic is_div;
      logic div_last;
   } sts_type;

endpackage

// ----- design/rv32im_instruction_execute.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32IM instruction execute
// Multicycle RV32IM execute unit with its own register file.
// Steps: read operands, execute and respond; multiply adds a product step, and
// divide and remainder add a start step and a divider loop (one quotient bit per cycle in the divider).
// One request at a time: a new request is accepted only when the response is taken.
// Reset: synchronous; clears the pending load; register file is zero.
// ----------------------------------------------------------------------------
module rv32im_instruction_execute import rv32_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   rv32_control u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rv32_datapath u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_data),
      .cmd   (cmd),
      .sts   (sts),
      .rsp   (rsp_data)
   );

endmodule

// ----- design/rv32_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32IM execute datapath
// Register file, decode, ALU, multiplier, radix-2 divider and response.
// ----------------------------------------------------------------------------
module rv32_datapath import rv32_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp
);

   logic [31:0] regs [32];
   req_type     req_ff;
   logic [31:0] a_ff, b_ff, x10_ff;
   logic        pend_ff;
   logic [4:0]  ldst_ff;
   logic [2:0]  lkind_ff;
   rsp_type     rsp_ff;
   logic [63:0] prod_ff;
   logic [31:0] quo_ff, rem_ff, dvs_ff;
   logic [4:0]  cnt_ff;
   logic        neg_q_ff, neg_r_ff;

   logic        we;
   logic [4:0]  wa;
   logic [31:0] wd;
   rsp_type     r;
   logic        pend_in;
   logic [4:0]  ldst_in;
   logic [2:0]  lkind_in;

   logic [31:0] w;
   logic [6:0]  op, f7;
   logic [2:0]  f3;
   logic [4:0]  rd;
   logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j, pc4;
   logic        lts, take;
   logic [32:0] ma, mb;
   logic [63:0] mp;
   logic [32:0] trial;
   logic [31:0] rem_sh, lv, div_res;

   assign w     = req_ff.instruction;
   assign op    = w[6:0];
   assign rd    = w[11:7];
   assign f3    = w[14:12];
   assign f7    = w[31:25];
   assign imm_i = {{20{w[31]}}, w[31:20]};
   assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
   assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
   assign imm_u = {w[31:12], 12'd0};
   assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
   assign pc4   = req_ff.pc + 32'd4;
   assign lts   = $signed(a_ff) < $signed(b_ff);

   assign sts.is_data  = req_ff.mode;
   assign sts.is_mul   = (op == OpReg) && (f7 == F7Mul) && !f3[2];
   assign sts.is_div   = (op == OpReg) && (f7 == F7Mul) && f3[2];
   assign sts.div_last = (cnt_ff == 5'd31);

   // multiplier operands
   assign ma = {(f3 == 3'd1 || f3 == 3'd2) && a_ff[31], a_ff};
   assign mb = {(f3 == 3'd1) && b_ff[31], b_ff};
   assign mp = $signed(ma) * $signed(mb);

   assign rem_sh = {rem_ff[30:0], quo_ff[31]};
   assign trial  = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req;
      if (cmd.read) begin
         a_ff   <= (w[19:15] == 5'd0) ? 32'd0 : regs[w[19:15]];
         b_ff   <= (w[24:20] == 5'd0) ? 32'd0 : regs[w[24:20]];
         x10_ff <= regs[10];
      end
      if (cmd.exec || cmd.div_finish) rsp_ff <= r;
      if (cmd.mul_hi) prod_ff <= mp;
      if (cmd.div_start) begin
         quo_ff   <= (!f3[0] && a_ff[31]) ? -a_ff : a_ff;
         dvs_ff   <= (!f3[0] && b_ff[31]) ? -b_ff : b_ff;
         rem_ff   <= 32'd0;
         cnt_ff   <= 5'd0;
         neg_q_ff <= !f3[0] && (a_ff[31] ^ b_ff[31]);
         neg_r_ff <= !f3[0] && a_ff[31];
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + 5'd1;
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         ldst_ff  <= 5'd0;
         lkind_ff <= 3'd0;
         for (int i = 0; i < 32; i++) regs[i] <= 32'd0;
      end else begin
         pend_ff  <= pend_in;
         ldst_ff  <= ldst_in;
         lkind_ff <= lkind_in;
         if (we) regs[wa] <= wd;
      end
   end

   always_comb begin
      case (lkind_ff)
         3'd0:    lv = {{24{req_ff.load_data[7]}}, req_ff.load_data[7:0]};
         3'd1:    lv = {{16{req_ff.load_data[15]}}, req_ff.load_data[15:0]};
         3'd4:    lv = {24'd0, req_ff.load_data[7:0]};
         3'd5:    lv = {16'd0, req_ff.load_data[15:0]};
         default: lv = req_ff.load_data;
      endcase
   end

   always_comb begin
      if (b_ff == 32'd0)
         div_res = f3[1] ? a_ff : 32'hffff_ffff;
      else if (f3[1])
         div_res = neg_r_ff ? -rem_ff : rem_ff;
      else
         div_res = neg_q_ff ? -quo_ff : quo_ff;
   end

   always_comb begin
      r        = '0;
      we       = 1'b0;
      wa       = rd;
      wd       = 32'd0;
      take     = 1'b0;
      pend_in  = pend_ff;
      ldst_in  = ldst_ff;
      lkind_in = lkind_ff;
      if (cmd.div_finish) begin
         we        = 1'b1;
         wd        = div_res;
         pend_in   = 1'b0;
         r.next_pc = pc4;
      end else if (cmd.exec && req_ff.mode) begin
         if (!pend_ff) begin
            r.status = StStray;
         end else begin
            we      = 1'b1;
            wa      = ldst_ff;
            wd      = lv;
            pend_in = 1'b0;
         end
      end else if (cmd.exec) begin
         pend_in   = 1'b0;
         r.next_pc = pc4;
         case (op)
            OpLui: begin
               we = 1'b1; wd = imm_u;
            end
            OpAuipc: begin
               we = 1'b1; wd = req_ff.pc + imm_u;
            end
            OpJal: begin
               we = 1'b1; wd = pc4; r.next_pc = req_ff.pc + imm_j;
            end
            OpJalr: begin
               if (f3 != 3'd0) r.status = StIllegal;
               else begin
                  we = 1'b1; wd = pc4;
                  r.next_pc = (a_ff + imm_i) & ~32'd1;
               end
            end
            OpBranch: begin
               case (f3)
                  3'd0:    take = a_ff == b_ff;
                  3'd1:    take = a_ff != b_ff;
                  3'd4:    take = lts;
                  3'd5:    take = !lts;
                  3'd6:    take = a_ff < b_ff;
                  3'd7:    take = a_ff >= b_ff;
                  default: r.status = StIllegal;
               endcase
               if (take) r.next_pc = req_ff.pc + imm_b;
            end
            OpLoad: begin
               if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) r.status = StIllegal;
               else begin
                  r.mem_valid   = 1'b1;
                  r.mem_bytes   = 3'd1 << f3[1:0];
                  r.mem_address = a_ff + imm_i;
                  r.status      = StAwait;
                  pend_in  = 1'b1;
                  ldst_in  = rd;
                  lkind_in = f3;
               end
            end
            OpStore: begin
               if (f3[2] || f3 == 3'd3) r.status = StIllegal;
               else begin
                  r.mem_valid   = 1'b1;
                  r.mem_write   = 1'b1;
                  r.mem_bytes   = 3'd1 << f3[1:0];
                  r.mem_address = a_ff + imm_s;
                  r.store_value = b_ff;
               end
            end
            OpImm: begin
               we = 1'b1;
               case (f3)
                  3'd0: wd = a_ff + imm_i;
                  3'd2: wd = {31'd0, $signed(a_ff) < $signed(imm_i)};
                  3'd3: wd = {31'd0, a_ff < imm_i};
                  3'd4: wd = a_ff ^ imm_i;
                  3'd6: wd = a_ff | imm_i;
                  3'd7: wd = a_ff & imm_i;
                  3'd1: begin
                     if (f7 != F7Base) begin r.status = StIllegal; we = 1'b0; end
                     wd = a_ff << imm_i[4:0];
                  end
                  default: begin
                     if (f7 == F7Base) wd = a_ff >> imm_i[4:0];
                     else if (f7 == F7Alt) wd = $unsigned($signed(a_ff) >>> imm_i[4:0]);
                     else begin r.status = StIllegal; we = 1'b0; end
                  end
               endcase
            end
            OpReg: begin
               we = 1'b1;
               if (f7 == F7Base) begin
                  case (f3)
                     3'd0:    wd = a_ff + b_ff;
                     3'd1:    wd = a_ff << b_ff[4:0];
                     3'd2:    wd = {31'd0, lts};
                     3'd3:    wd = {31'd0, a_ff < b_ff};
                     3'd4:    wd = a_ff ^ b_ff;
                     3'd5:    wd = a_ff >> b_ff[4:0];
                     3'd6:    wd = a_ff | b_ff;
                     default: wd = a_ff & b_ff;
                  endcase
               end else if (f7 == F7Alt && f3 == 3'd0) wd = a_ff - b_ff;
               else if (f7 == F7Alt && f3 == 3'd5)
                  wd = $unsigned($signed(a_ff) >>> b_ff[4:0]);
               else if (f7 == F7Mul && !f3[2])
                  wd = (f3 == 3'd0) ? prod_ff[31:0] : prod_ff[63:32];
               else begin
                  r.status = StIllegal; we = 1'b0;
               end
            end
            OpSystem: begin
               if (w == WordEbreak) begin
                  r.status = StHalt; r.halt_code = x10_ff;
               end else r.status = StIllegal;
            end
            default: r.status = StIllegal;
         endcase
      end
      we = (cmd.exec || cmd.div_finish) && we && (wa != 5'd0);
   end

   assign rsp = rsp_ff;

endmodule

// ----- design/rv32_control.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32IM execute controller
// Sequences read, execute, multiply and divide steps and the handshake.
// ----------------------------------------------------------------------------
module rv32_control import rv32_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_READ;
         S_READ: begin
            if (sts.is_data)     state_in = S_EXEC;
            else if (sts.is_mul) state_in = S_MUL;
            else if (sts.is_div) state_in = S_DSTART;
            else                 state_in = S_EXEC;
         end
         S_MUL:    state_in = S_EXEC;
         S_DSTART: state_in = S_DIV;
         S_DIV:    if (sts.div_last) state_in = S_EXEC;
         S_EXEC:   state_in = S_DONE;
         S_DONE:   if (rsp_ready) state_in = req_valid ? S_READ : S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_READ: begin
            cmd.read = 1'b1;
         end
         S_MUL:    cmd.mul_hi = 1'b1;
         S_DSTART: cmd.div_start = 1'b1;
         S_DIV:    cmd.div_step = 1'b1;
         S_EXEC: begin
            if (!sts.is_data && sts.is_div) cmd.div_finish = 1'b1;
            else                            cmd.exec = 1'b1;
         end
         S_DONE: begin
            rsp_valid   = 1'b1;
            req_ready   = rsp_ready;
            cmd.capture = rsp_ready && req_valid;
         end
         default: ;
      endcase
   end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32IM instruction execute testbench
// Drives execute and load-data requests with random gaps, predicts each
// response from a private copy of the register file and checks every field.
// ----------------------------------------------------------------------------
module tb import rv32_pkg::*; ();

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   rv32im_instruction_execute u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   req_type     pending_reqs[$];
   rsp_type     expected_rsps[$];
   logic [31:0] regs[32];
   logic        ld_pending;
   logic [4:0]  ld_dest;
   logic [2:0]  ld_kind;
   int          errors;
   int          req_wait;
   int          rsp_wait;
   bit          stim_done;

   initial clock = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [31:0] rd_val(logic [4:0] idx);
      return (idx == 5'd0) ? 32'd0 : regs[idx];
   endfunction

   function automatic void wr_val(logic [4:0] idx, logic [31:0] v);
      if (idx != 5'd0) regs[idx] = v;
   endfunction

   function automatic logic [31:0] op_reg(logic [2:0] f3, logic [31:0] a, logic [31:0] b,
                                          ref logic ok);
      logic signed [63:0] pr;
      logic [63:0] pu;
      logic [31:0] q;
      ok = 1'b1;
      pu = {32'd0, a} * {32'd0, b};
      case (f3)
         3'd0: return pu[31:0];
         3'd1: begin
            pr = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
            return pr[63:32];
         end
         3'd2: begin
            pr = $signed({{32{a[31]}}, a}) * $signed({32'd0, b});
            return pr[63:32];
         end
         3'd3: return pu[63:32];
         3'd4: begin
            if (b == 0) return 32'hffffffff;
            q = (a[31] ? -a : a) / (b[31] ? -b : b);
            return (a[31] != b[31]) ? -q : q;
         end
         3'd5: return (b == 0) ? 32'hffffffff : a / b;
         3'd6: begin
            if (b == 0) return a;
            q = (a[31] ? -a : a) % (b[31] ? -b : b);
            return a[31] ? -q : q;
         end
         default: return (b == 0) ? a : a % b;
      endcase
   endfunction

   function automatic rsp_type execute_model(req_type r);
      rsp_type o;
      logic [31:0] w, a, b, ii, is_, ib, iu, ij, res;
      logic [4:0] rd;
      logic [2:0] f3;
      logic [6:0] f7;
      logic take, ok;
      o = '0;
      if (r.mode) begin
         if (!ld_pending) o.status = StStray;
         else begin
            case (ld_kind)
               3'd0: res = {{24{r.load_data[7]}}, r.load_data[7:0]};
               3'd1: res = {{16{r.load_data[15]}}, r.load_data[15:0]};
               3'd4: res = {24'd0, r.load_data[7:0]};
               3'd5: res = {16'd0, r.load_data[15:0]};
               default: res = r.load_data;
            endcase
            wr_val(ld_dest, res);
            ld_pending = 1'b0;
         end
         return o;
      end
      w = r.instruction;
      rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
      a = rd_val(w[19:15]); b = rd_val(w[24:20]);
      ii = {{20{w[31]}}, w[31:20]};
      is_ = {{20{w[31]}}, w[31:25], w[11:7]};
      ib = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      iu = {w[31:12], 12'd0};
      ij = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      ld_pending = 1'b0;
      o.next_pc = r.pc + 4;
      case (w[6:0])
         OpLui: wr_val(rd, iu);
         OpAuipc: wr_val(rd, r.pc + iu);
         OpJal: begin wr_val(rd, r.pc + 4); o.next_pc = r.pc + ij; end
         OpJalr: begin
            if (f3 != 0) o.status = StIllegal;
            else begin
               o.next_pc = (a + ii) & ~32'd1;
               wr_val(rd, r.pc + 4);
            end
         end
         OpBranch: begin
            take = 1'b0;
            case (f3)
               3'd0: take = a == b;
               3'd1: take = a != b;
               3'd4: take = $signed(a) < $signed(b);
               3'd5: take = $signed(a) >= $signed(b);
               3'd6: take = a < b;
               3'd7: take = a >= b;
               default: o.status = StIllegal;
            endcase
            if (take) o.next_pc = r.pc + ib;
         end
         OpLoad: begin
            if (f3 == 3 || f3 > 5) o.status = StIllegal;
            else begin
               o.mem_valid = 1'b1;
               o.mem_bytes = 3'd1 << f3[1:0];
               o.mem_address = a + ii;
               ld_pending = 1'b1; ld_dest = rd; ld_kind = f3;
               o.status = StAwait;
            end
         end
         OpStore: begin
            if (f3 > 2) o.status = StIllegal;
            else begin
               o.mem_valid = 1'b1; o.mem_write = 1'b1;
               o.mem_bytes = 3'd1 << f3[1:0];
               o.mem_address = a + is_;
               o.store_value = b;
            end
         end
         OpImm: begin
            case (f3)
               3'd0: wr_val(rd, a + ii);
               3'd2: wr_val(rd, {31'd0, $signed(a) < $signed(ii)});
               3'd3: wr_val(rd, {31'd0, a < ii});
               3'd4: wr_val(rd, a ^ ii);
               3'd6: wr_val(rd, a | ii);
               3'd7: wr_val(rd, a & ii);
               3'd1: begin
                  if (f7 != F7Base) o.status = StIllegal;
                  else wr_val(rd, a << ii[4:0]);
               end
               default: begin
                  if (f7 == F7Base) wr_val(rd, a >> ii[4:0]);
                  else if (f7 == F7Alt) wr_val(rd, $signed(a) >>> ii[4:0]);
                  else o.status = StIllegal;
               end
            endcase
         end
         OpReg: begin
            ok = 1'b1;
            if (f7 == F7Base) begin
               case (f3)
                  3'd0: res = a + b;
                  3'd1: res = a << b[4:0];
                  3'd2: res = {31'd0, $signed(a) < $signed(b)};
                  3'd3: res = {31'd0, a < b};
                  3'd4: res = a ^ b;
                  3'd5: res = a >> b[4:0];
                  3'd6: res = a | b;
                  default: res = a & b;
               endcase
            end else if (f7 == F7Alt && f3 == 3'd0) res = a - b;
            else if (f7 == F7Alt && f3 == 3'd5) res = $signed(a) >>> b[4:0];
            else if (f7 == F7Mul) res = op_reg(f3, a, b, ok);
            else ok = 1'b0;
            if (ok) wr_val(rd, res);
            else o.status = StIllegal;
         end
         OpSystem: begin
            if (w == WordEbreak) begin o.status = StHalt; o.halt_code = rd_val(5'd10); end
            else o.status = StIllegal;
         end
         default: o.status = StIllegal;
      endcase
      if (o.status == StIllegal) o.next_pc = r.pc + 4;
      return o;
   endfunction

   function automatic req_type mk_exec(logic [31:0] w);
      req_type r;
      r.mode = 1'b0; r.instruction = w; r.pc = $urandom;
      r.load_data = $urandom;
      return r;
   endfunction

   function automatic req_type mk_data(logic [31:0] d);
      req_type r;
      r.mode = 1'b1; r.instruction = $urandom; r.pc = $urandom; r.load_data = d;
      return r;
   endfunction

   function automatic logic [31:0] rand_word();
      logic [6:0] ops[10];
      logic [31:0] w;
      int k;
      ops = '{OpLui, OpAuipc, OpJal, OpJalr, OpBranch, OpLoad, OpStore, OpImm, OpReg,
              OpSystem};
      w = $urandom;
      k = $urandom_range(0, 99);
      if (k < 3) return WordEbreak;
      if (k < 8) return w;
      w[6:0] = ops[$urandom_range(0, 9)];
      if (w[6:0] == OpReg || (w[6:0] == OpImm && w[13:12] == 2'b01)) begin
         case ($urandom_range(0, 7))
            0, 1, 2: w[31:25] = F7Base;
            3: w[31:25] = F7Alt;
            4, 5, 6: w[31:25] = F7Mul;
            default: ;
         endcase
      end
      if ($urandom_range(0, 3) == 0) w[19:15] = 5'd0;
      return w;
   endfunction

   initial begin
      int n;
      logic [31:0] w;
      errors = 0;
      stim_done = 1'b0;
      // directed: fill registers with extremes, then special cases
      pending_reqs.push_back(mk_data(32'h1234));
      pending_reqs.push_back(mk_exec({20'h80000, 5'd1, OpLui}));
      pending_reqs.push_back(mk_exec({12'hfff, 5'd0, 3'd0, 5'd2, OpImm}));
      pending_reqs.push_back(mk_exec({F7Mul, 5'd2, 5'd1, 3'd4, 5'd3, OpReg}));
      pending_reqs.push_back(mk_exec({F7Mul, 5'd2, 5'd1, 3'd6, 5'd4, OpReg}));
      pending_reqs.push_back(mk_exec({F7Mul, 5'd0, 5'd1, 3'd4, 5'd5, OpReg}));
      pending_reqs.push_back(mk_exec({F7Mul, 5'd0, 5'd1, 3'd7, 5'd6, OpReg}));
      pending_reqs.push_back(mk_exec({F7Base, 5'd2, 5'd1, 3'd0, 5'd10, OpReg}));
      pending_reqs.push_back(mk_exec(WordEbreak));
      pending_reqs.push_back(mk_exec(32'h0000_000f));
      pending_reqs.push_back(mk_exec(32'h0000_0073));
      pending_reqs.push_back(mk_exec({12'h7ff, 5'd1, 3'd0, 5'd0, OpLoad}));
      pending_reqs.push_back(mk_data(32'hffffffff));
      pending_reqs.push_back(mk_exec({12'h800, 5'd2, 3'd4, 5'd7, OpLoad}));
      pending_reqs.push_back(mk_exec({12'h001, 5'd2, 3'd1, 5'd8, OpLoad}));
      pending_reqs.push_back(mk_data(32'h0000_8000));
      pending_reqs.push_back(mk_data(32'h0));
      pending_reqs.push_back(mk_exec({7'h7f, 5'd2, 5'd1, 3'd2, 5'h1f, OpStore}));
      pending_reqs.push_back(mk_exec({1'b1, 10'h3ff, 1'b1, 8'hff, 5'd9, OpJal}));
      pending_reqs.push_back(mk_exec({12'hfff, 5'd2, 3'd0, 5'd9, OpJalr}));
      pending_reqs.push_back(mk_exec({7'h7f, 5'd2, 5'd1, 3'd4, 5'h1f, OpBranch}));
      pending_reqs.push_back(mk_exec({F7Alt, 5'd2, 5'd1, 3'd5, 5'd11, OpReg}));
      n = 0;
      while (n < 1950) begin
         w = rand_word();
         pending_reqs.push_back(mk_exec(w));
         n++;
         if (w[6:0] == OpLoad && $urandom_range(0, 9) != 0) begin
            pending_reqs.push_back(mk_data($urandom));
            n++;
         end else if ($urandom_range(0, 40) == 0) begin
            pending_reqs.push_back(mk_data($urandom));
            n++;
         end
      end
      stim_done = 1'b1;
   end

   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // driver
   initial begin
      req_valid = 1'b0; req_data = '0; req_wait = 0;
      foreach (regs[i]) regs[i] = 32'd0;
      ld_pending = 1'b0; ld_dest = 5'd0; ld_kind = 3'd0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_rsps.push_back(execute_model(req_data));
            req_valid <= 1'b0;
            req_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
         end else if (!req_valid) begin
            if (req_wait > 0) req_wait--;
            else if (pending_reqs.size() > 0) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end
         end
      end
   end

   // monitor
   initial begin
      rsp_ready = 1'b0; rsp_wait = 0;
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t unexpected response: expected none, actual %h", $time, rsp_data);
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (e !== rsp_data) begin
                  $display("%0t mismatch: expected %h, actual %h", $time, e, rsp_data);
                  errors++;
               end
            end
            rsp_ready <= 1'b0;
            rsp_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
         end else if (!rsp_ready) begin
            if (rsp_wait > 0) rsp_wait--;
            else rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      @(negedge reset);
      wait (stim_done && pending_reqs.size() == 0 && !req_valid &&
            expected_rsps.size() == 0);
      repeat (80) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) $display("[rv32im_instruction_execute] OK");
      else $display("[rv32im_instruction_execute] ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("[rv32im_instruction_execute] ERROR");
      $finish;
   end

endmodule
